@@ hdl/spuadpcm_pkg.sv @@
// Package for the SPU ADPCM block decoder.
// Holds the transfer types, the state encoding, the filter coefficients and the
// default parameter values; it depends on nothing.
package spuadpcm_pkg;

    localparam int DEF_INTERLEAVE_BYTES = 256;
    localparam int DEF_NUM_CHANNELS     = 2;

    localparam int BLOCK_BYTES = 16;
    localparam int NUM_FILTERS = 5;
    localparam int MAX_SHIFT   = 12;

    localparam int HIST_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 8;
    localparam int PROD_W   = HIST_W + COEF_W;
    localparam int ACC_W    = 36;

    localparam logic [3:0] BYTE_HEADER = 4'd0;
    localparam logic [3:0] BYTE_FLAGS  = 4'd1;
    localparam logic [3:0] BYTE_LAST   = 4'd15;

    localparam logic [7:0] FLAGS_REPEAT = 8'h03;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_first;
        logic signed [SAMPLE_W-1:0] sample_second;
        logic                       channel_id;
        logic                       block_good;
        logic                       loop_start_mark;
        logic                       loop_end_mark;
        logic                       loop_repeat;
        logic                       block_last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL0,
        ST_SUM0,
        ST_MUL1,
        ST_SUM1,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load;
        logic [2:0] filter;
        logic [3:0] shift;
        logic [3:0] nibble;
    } filt_ctrl_t;

    function automatic logic signed [COEF_W-1:0] coef_recent(input logic [2:0] filter);
        logic signed [COEF_W-1:0] c;
        case (filter)
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] coef_older(input logic [2:0] filter);
        logic signed [COEF_W-1:0] c;
        case (filter)
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/spuadpcm_filter.sv @@
// Prediction filter for one ADPCM nibble, shared by both nibbles of a byte.
// The load cycle registers the scaled nibble and both history products; the
// next cycle sums them and saturates. Depends on spuadpcm_pkg.
module spuadpcm_filter (
    input  logic                                    clk,
    input  spuadpcm_pkg::filt_ctrl_t                ctrl,
    input  logic signed [spuadpcm_pkg::HIST_W-1:0]  hist_recent,
    input  logic signed [spuadpcm_pkg::HIST_W-1:0]  hist_older,
    output logic signed [spuadpcm_pkg::HIST_W-1:0]  cur_sat,
    output logic signed [spuadpcm_pkg::SAMPLE_W-1:0] sample
);

    localparam int PW = spuadpcm_pkg::PROD_W;
    localparam int AW = spuadpcm_pkg::ACC_W;
    localparam int HW = spuadpcm_pkg::HIST_W;
    localparam int SW = spuadpcm_pkg::SAMPLE_W;

    logic signed [PW-1:0] prod_recent;
    logic signed [PW-1:0] prod_older;
    logic signed [PW-1:0] adj_recent;
    logic signed [PW-1:0] adj_older;
    logic signed [15:0]   scaled;
    logic signed [15:0]   scaled_reg;
    logic signed [AW-1:0] term_recent_reg;
    logic signed [AW-1:0] term_older_reg;
    logic signed [AW-1:0] cur;
    logic signed [AW-1:0] rounded;
    logic signed [AW-1:0] quot;
    logic                 fits_hist;
    logic                 fits_sample;

    always_comb
    begin
        prod_recent = hist_recent * spuadpcm_pkg::coef_recent(ctrl.filter);
        prod_older  = hist_older * spuadpcm_pkg::coef_older(ctrl.filter);
        adj_recent  = prod_recent + PW'({6{prod_recent[PW-1]}});
        adj_older   = prod_older + PW'({6{prod_older[PW-1]}});
        scaled      = $signed({ctrl.nibble, 12'b0}) >>> ctrl.shift;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            scaled_reg      <= scaled;
            term_recent_reg <= AW'(adj_recent >>> 6);
            term_older_reg  <= AW'(adj_older >>> 6);
        end
    end

    always_comb
    begin
        cur       = (AW'(scaled_reg) <<< 6) + term_recent_reg + term_older_reg;
        fits_hist = (cur[AW-1:HW-1] == {(AW-HW+1){cur[AW-1]}});
        if (fits_hist)
            cur_sat = cur[HW-1:0];
        else if (cur[AW-1])
            cur_sat = {1'b1, {(HW-1){1'b0}}};
        else
            cur_sat = {1'b0, {(HW-1){1'b1}}};

        rounded     = cur + AW'(32);
        quot        = $signed(rounded + AW'({6{rounded[AW-1]}})) >>> 6;
        fits_sample = (quot[AW-1:SW-1] == {(AW-SW+1){quot[AW-1]}});
        if (fits_sample)
            sample = quot[SW-1:0];
        else if (quot[AW-1])
            sample = {1'b1, {(SW-1){1'b0}}};
        else
            sample = {1'b0, {(SW-1){1'b1}}};
    end

endmodule

@@ hdl/spu_adpcm_block_decoder.sv @@
// Top level of the SPU ADPCM block decoder: byte position, block header,
// per-channel history memory and the output register.
// Depends on spuadpcm_pkg and spuadpcm_filter.
//
// The input channel (in_valid, in_ready, in_data) takes one byte of an
// interleaved stream of 16-byte ADPCM blocks per transfer. Pages of
// INTERLEAVE_BYTES bytes go to channels 0 .. NUM_CHANNELS-1 in turn. Setting
// stream_start on a byte restarts the position and clears all histories.
// Header bytes, flag bytes and page tail bytes produce no result; the block stays
// idle for them. A sample byte with a good header holds in_ready low from its
// transfer until its result is loaded: one history memory read, then a
// multiply step and a sum step for each of its two nibbles through the single
// filter unit, then the result register load. A sample byte of a bad block skips
// the filter and gives zero samples through the result register.
// Histories live in a memory with one read port and one write port; a valid bit
// per channel makes a cleared channel read as zero, so reset needs no sweep.
// After reset the block is at position zero with empty histories. When the
// receiver stalls, the held result waits in the output register; the next input
// is still taken, and its own result waits until that register is free.
module spu_adpcm_block_decoder #(
    parameter int INTERLEAVE_BYTES = spuadpcm_pkg::DEF_INTERLEAVE_BYTES,
    parameter int NUM_CHANNELS     = spuadpcm_pkg::DEF_NUM_CHANNELS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  spuadpcm_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output spuadpcm_pkg::out_item_t out_data
);

    localparam int WITHIN_W    = $clog2(INTERLEAVE_BYTES);
    localparam int CH_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PAGE_BLOCKS = (INTERLEAVE_BYTES / spuadpcm_pkg::BLOCK_BYTES)
                                 * spuadpcm_pkg::BLOCK_BYTES;
    localparam int HW          = spuadpcm_pkg::HIST_W;

    spuadpcm_pkg::state_t     state_reg;
    spuadpcm_pkg::state_t     state_next;
    spuadpcm_pkg::filt_ctrl_t filt_ctrl;
    spuadpcm_pkg::out_item_t  pend_reg;
    spuadpcm_pkg::out_item_t  out_reg;

    logic [WITHIN_W-1:0]   within_reg;
    logic [WITHIN_W-1:0]   within_next;
    logic [CH_W-1:0]       ch_reg;
    logic [CH_W-1:0]       ch_next;
    logic [WITHIN_W-1:0]   cur_within;
    logic [CH_W-1:0]       cur_ch;
    logic [CH_W-1:0]       item_ch_reg;
    logic [2:0]            filter_reg;
    logic [3:0]            shift_reg;
    logic                  hdr_valid_reg;
    logic [7:0]            flags_reg;
    logic [NUM_CHANNELS-1:0] hist_vld_reg;
    logic [7:0]            byte_reg;
    logic [2*HW-1:0]       mem [NUM_CHANNELS];
    logic [2*HW-1:0]       rd_data_reg;
    logic                  rd_vld_reg;
    logic                  mem_we;
    logic signed [HW-1:0]  h1_reg;
    logic signed [HW-1:0]  h2_reg;
    logic signed [HW-1:0]  op_recent;
    logic signed [HW-1:0]  op_older;
    logic signed [HW-1:0]  cur_sat;
    logic signed [spuadpcm_pkg::SAMPLE_W-1:0] sample;
    logic                  out_valid_reg;
    logic                  accept;
    logic                  in_tail;
    logic [3:0]            byte_idx;
    logic                  hdr_bad;
    logic                  is_sample;
    logic                  emit_fire;

    assign in_ready  = (state_reg == spuadpcm_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign emit_fire = (state_reg == spuadpcm_pkg::ST_EMIT) && (!out_valid_reg || out_ready);
    assign mem_we    = (state_reg == spuadpcm_pkg::ST_SUM1);

    always_comb
    begin
        cur_ch     = in_data.stream_start ? '0 : ch_reg;
        cur_within = in_data.stream_start ? '0 : within_reg;
        in_tail    = ({1'b0, cur_within} >= (WITHIN_W+1)'(PAGE_BLOCKS));
        byte_idx   = cur_within[3:0];
        hdr_bad    = (in_data.data_byte[7:4] >= 4'(spuadpcm_pkg::NUM_FILTERS))
                     || (in_data.data_byte[3:0] > 4'(spuadpcm_pkg::MAX_SHIFT));
        is_sample  = !in_tail && (byte_idx != spuadpcm_pkg::BYTE_HEADER)
                     && (byte_idx != spuadpcm_pkg::BYTE_FLAGS);
        if (cur_within == WITHIN_W'(INTERLEAVE_BYTES - 1))
        begin
            within_next = '0;
            ch_next     = (cur_ch == CH_W'(NUM_CHANNELS - 1)) ? '0 : cur_ch + CH_W'(1);
        end
        else
        begin
            within_next = cur_within + WITHIN_W'(1);
            ch_next     = cur_ch;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spuadpcm_pkg::ST_IDLE:
            begin
                if (accept && is_sample)
                    state_next = hdr_valid_reg ? spuadpcm_pkg::ST_READ : spuadpcm_pkg::ST_EMIT;
            end
            spuadpcm_pkg::ST_READ: state_next = spuadpcm_pkg::ST_MUL0;
            spuadpcm_pkg::ST_MUL0: state_next = spuadpcm_pkg::ST_SUM0;
            spuadpcm_pkg::ST_SUM0: state_next = spuadpcm_pkg::ST_MUL1;
            spuadpcm_pkg::ST_MUL1: state_next = spuadpcm_pkg::ST_SUM1;
            spuadpcm_pkg::ST_SUM1: state_next = spuadpcm_pkg::ST_EMIT;
            spuadpcm_pkg::ST_EMIT:
            begin
                if (emit_fire)
                    state_next = spuadpcm_pkg::ST_IDLE;
            end
            default: state_next = spuadpcm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spuadpcm_pkg::ST_IDLE;
            within_reg    <= '0;
            ch_reg        <= '0;
            filter_reg    <= '0;
            shift_reg     <= '0;
            hdr_valid_reg <= 1'b0;
            flags_reg     <= '0;
            hist_vld_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (mem_we)
                hist_vld_reg[item_ch_reg] <= 1'b1;
            if (accept)
            begin
                within_reg <= within_next;
                ch_reg     <= ch_next;
                if (in_data.stream_start)
                begin
                    hist_vld_reg <= '0;
                    flags_reg    <= '0;
                end
                if (!in_tail && byte_idx == spuadpcm_pkg::BYTE_HEADER)
                begin
                    if (hdr_bad)
                    begin
                        hdr_valid_reg <= 1'b0;
                        filter_reg    <= '0;
                        shift_reg     <= '0;
                        if (!in_data.stream_start)
                            hist_vld_reg[cur_ch] <= 1'b0;
                    end
                    else
                    begin
                        hdr_valid_reg <= 1'b1;
                        filter_reg    <= in_data.data_byte[6:4];
                        shift_reg     <= in_data.data_byte[3:0];
                    end
                end
                if (!in_tail && byte_idx == spuadpcm_pkg::BYTE_FLAGS)
                    flags_reg <= in_data.data_byte;
            end
        end
    end

    always_comb
    begin
        if (state_reg == spuadpcm_pkg::ST_MUL0)
        begin
            op_recent = rd_vld_reg ? rd_data_reg[2*HW-1:HW] : '0;
            op_older  = rd_vld_reg ? rd_data_reg[HW-1:0] : '0;
        end
        else
        begin
            op_recent = h1_reg;
            op_older  = h2_reg;
        end
        filt_ctrl.load   = (state_reg == spuadpcm_pkg::ST_MUL0)
                           || (state_reg == spuadpcm_pkg::ST_MUL1);
        filt_ctrl.filter = filter_reg;
        filt_ctrl.shift  = shift_reg;
        filt_ctrl.nibble = (state_reg == spuadpcm_pkg::ST_MUL0) ? byte_reg[3:0] : byte_reg[7:4];
    end

    spuadpcm_filter u_filter (
        .clk         (clk),
        .ctrl        (filt_ctrl),
        .hist_recent (op_recent),
        .hist_older  (op_older),
        .cur_sat     (cur_sat),
        .sample      (sample)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[item_ch_reg] <= {cur_sat, h1_reg};
        if (state_reg == spuadpcm_pkg::ST_READ)
        begin
            rd_data_reg <= mem[item_ch_reg];
            rd_vld_reg  <= hist_vld_reg[item_ch_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_ch_reg              <= cur_ch;
            byte_reg                 <= in_data.data_byte;
            pend_reg.sample_first    <= '0;
            pend_reg.sample_second   <= '0;
            pend_reg.channel_id      <= cur_ch[0];
            pend_reg.block_good      <= hdr_valid_reg;
            pend_reg.loop_start_mark <= flags_reg[2];
            pend_reg.loop_end_mark   <= flags_reg[0];
            pend_reg.loop_repeat     <= (flags_reg == spuadpcm_pkg::FLAGS_REPEAT);
            pend_reg.block_last      <= (byte_idx == spuadpcm_pkg::BYTE_LAST);
        end
        case (state_reg)
            spuadpcm_pkg::ST_MUL0:
            begin
                h1_reg <= op_recent;
                h2_reg <= op_older;
            end
            spuadpcm_pkg::ST_SUM0:
            begin
                h2_reg                <= h1_reg;
                h1_reg                <= cur_sat;
                pend_reg.sample_first <= sample;
            end
            spuadpcm_pkg::ST_SUM1:
            begin
                pend_reg.sample_second <= sample;
            end
            default:
            begin
            end
        endcase
        if (emit_fire)
            out_reg <= pend_reg;
    end

`ifndef ASSERT_OFF
    a_start_clears_history: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.stream_start) |=> (hist_vld_reg == '0))
        else $error("stream start did not clear the channel histories");

    a_writeback_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (state_reg == spuadpcm_pkg::ST_EMIT) && hist_vld_reg[$past(item_ch_reg)])
        else $error("history write-back not followed by result emission");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> out_valid && (out_data == $past(pend_reg)))
        else $error("result register did not take the pending result");

    a_no_result_from_header: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_sample) |=> (state_reg == spuadpcm_pkg::ST_IDLE))
        else $error("header or tail byte started sample processing");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the SPU ADPCM block decoder.
// Depends on spuadpcm_pkg and spu_adpcm_block_decoder; every accepted byte feeds
// a decoder model kept in this file, and each result is checked against it.
module tb;

    localparam int INTERLEAVE       = spuadpcm_pkg::DEF_INTERLEAVE_BYTES;
    localparam int CHANNELS         = spuadpcm_pkg::DEF_NUM_CHANNELS;
    localparam int CYCLE_BYTES      = INTERLEAVE * CHANNELS;
    localparam int PAGE_BLOCK_BYTES = (INTERLEAVE / spuadpcm_pkg::BLOCK_BYTES)
                                      * spuadpcm_pkg::BLOCK_BYTES;
    localparam int RANDOM_BYTES     = 1100;
    localparam int HOLD_AT_RESULT   = 150;
    localparam int HOLD_CYCLES      = 300;
    localparam int DRAIN_CYCLES     = 16;

    typedef struct packed {
        spuadpcm_pkg::in_item_t item;
        logic [3:0]             gap;
    } queued_byte_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    spuadpcm_pkg::in_item_t  in_data = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    spuadpcm_pkg::out_item_t out_data;

    queued_byte_t            byte_queue[$];
    spuadpcm_pkg::out_item_t sample_pairs[$];

    longint tap_recent [0:4] = '{0, 60, 115, 98, 122};
    longint tap_older  [0:4] = '{0, 0, -52, -55, -60};

    int         model_pos;
    logic [2:0] model_filter;
    logic [3:0] model_shift;
    bit         model_hdr_ok;
    logic [7:0] model_flags;
    int         hist_recent [CHANNELS];
    int         hist_older  [CHANNELS];

    int  mismatches = 0;
    int  results_seen = 0;
    int  send_wait;
    int  recv_wait;
    int  hold_count = 0;
    bit  hold_started = 1'b0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;

    spu_adpcm_block_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int sat32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic logic signed [15:0] sat16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    task automatic clear_decoder();
        model_pos = 0;
        model_filter = '0;
        model_shift = '0;
        model_hdr_ok = 1'b0;
        model_flags = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            hist_recent[i] = 0;
            hist_older[i] = 0;
        end
    endtask

    function automatic logic signed [15:0] decode_nibble(input int ch, input logic [3:0] nib);
        longint scaled;
        longint cur;
        scaled = (longint'($signed(nib)) * 4096) >>> model_shift;
        cur = scaled * 64;
        cur = cur + (longint'(hist_recent[ch]) * tap_recent[model_filter]) / 64;
        cur = cur + (longint'(hist_older[ch]) * tap_older[model_filter]) / 64;
        hist_older[ch] = hist_recent[ch];
        hist_recent[ch] = sat32(cur);
        return sat16((cur + 32) / 64);
    endfunction

    task automatic decode_stream_byte(input spuadpcm_pkg::in_item_t it);
        int                      pos;
        int                      ch;
        int                      page_off;
        logic [3:0]              slot;
        spuadpcm_pkg::out_item_t pair;
        if (it.stream_start)
            clear_decoder();
        pos = model_pos;
        model_pos = (pos + 1 >= CYCLE_BYTES) ? 0 : pos + 1;
        ch = pos / INTERLEAVE;
        if (ch >= CHANNELS)
            ch = 0;
        page_off = pos % INTERLEAVE;
        if (page_off < PAGE_BLOCK_BYTES)
        begin
            slot = 4'(page_off);
            if (slot == spuadpcm_pkg::BYTE_HEADER)
            begin
                if (it.data_byte[7:4] >= spuadpcm_pkg::NUM_FILTERS
                    || it.data_byte[3:0] > spuadpcm_pkg::MAX_SHIFT)
                begin
                    model_hdr_ok = 1'b0;
                    model_filter = '0;
                    model_shift = '0;
                    hist_recent[ch] = 0;
                    hist_older[ch] = 0;
                end
                else
                begin
                    model_hdr_ok = 1'b1;
                    model_filter = it.data_byte[6:4];
                    model_shift = it.data_byte[3:0];
                end
            end
            else if (slot == spuadpcm_pkg::BYTE_FLAGS)
            begin
                model_flags = it.data_byte;
            end
            else
            begin
                pair = '0;
                if (model_hdr_ok)
                begin
                    pair.sample_first = decode_nibble(ch, it.data_byte[3:0]);
                    pair.sample_second = decode_nibble(ch, it.data_byte[7:4]);
                end
                pair.channel_id = ch[0];
                pair.block_good = model_hdr_ok;
                pair.loop_start_mark = model_flags[2];
                pair.loop_end_mark = model_flags[0];
                pair.loop_repeat = (model_flags == spuadpcm_pkg::FLAGS_REPEAT);
                pair.block_last = (slot == spuadpcm_pkg::BYTE_LAST);
                sample_pairs = {sample_pairs, pair};
            end
        end
    endtask

    task automatic check_pair(input spuadpcm_pkg::out_item_t got);
        spuadpcm_pkg::out_item_t want;
        bit                      bad;
        if (sample_pairs.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result: %0d %0d ch%0d good%0d", got.sample_first,
                         got.sample_second, got.channel_id, got.block_good);
        end
        else
        begin
            want = sample_pairs.pop_front();
            bad = (got.sample_first !== want.sample_first)
                || (got.sample_second !== want.sample_second)
                || (got.channel_id !== want.channel_id)
                || (got.block_good !== want.block_good)
                || (got.loop_start_mark !== want.loop_start_mark)
                || (got.loop_end_mark !== want.loop_end_mark)
                || (got.loop_repeat !== want.loop_repeat)
                || (got.block_last !== want.block_last);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Mismatch expected: %0d %0d ch%0d good%0d ls%0d le%0d rep%0d last%0d",
                             want.sample_first, want.sample_second, want.channel_id,
                             want.block_good, want.loop_start_mark, want.loop_end_mark,
                             want.loop_repeat, want.block_last);
                    $display("         actual:   %0d %0d ch%0d good%0d ls%0d le%0d rep%0d last%0d",
                             got.sample_first, got.sample_second, got.channel_id,
                             got.block_good, got.loop_start_mark, got.loop_end_mark,
                             got.loop_repeat, got.block_last);
                end
            end
        end
    endtask

    task automatic queue_byte(input logic [7:0] data, input bit start);
        queued_byte_t q;
        if ($urandom_range(0, 49) == 0)
            send_calm = !send_calm;
        q.item.data_byte = data;
        q.item.stream_start = start;
        q.gap = send_calm ? 4'd0 : 4'($urandom_range(0, 9));
        byte_queue = {byte_queue, q};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                decode_stream_byte(in_data);
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    in_valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (byte_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= byte_queue[0].item;
                    send_wait <= int'(byte_queue[0].gap);
                    byte_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            hold_started <= 1'b0;
        end
        else if (!hold_started && results_seen == HOLD_AT_RESULT)
        begin
            hold_count <= HOLD_CYCLES;
            hold_started <= 1'b1;
        end
        else if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        int w;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            w = recv_wait;
            if (out_valid && out_ready)
            begin
                check_pair(out_data);
                results_seen <= results_seen + 1;
                if ($urandom_range(0, 29) == 0)
                    recv_calm = !recv_calm;
                w = recv_calm ? 0 : $urandom_range(0, 9);
            end
            else if (w > 0)
            begin
                w = w - 1;
            end
            recv_wait <= w;
            out_ready <= (w == 0) && (hold_count == 0);
        end
    end

    initial
    begin : stimulus
        int         gen_pos;
        int         slot;
        bit         start;
        logic [7:0] data;

        // Short streams, each restarted, that touch every filter, both shift
        // limits, bad predictor and bad shift headers and the flag patterns.
        queue_byte(8'h40, 1'b1);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'h77, 1'b0);
        queue_byte(8'h88, 1'b0);
        queue_byte(8'h3C, 1'b1);
        queue_byte(8'h04, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h20, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h16, 1'b1);
        queue_byte(8'h07, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h50, 1'b1);
        queue_byte(8'h03, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h0D, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h77, 1'b0);

        gen_pos = 0;
        for (int k = 0; k < RANDOM_BYTES; k++)
        begin
            start = (k == 0);
            slot = gen_pos % spuadpcm_pkg::BLOCK_BYTES;
            if (slot >= 2 && $urandom_range(0, 199) == 0)
            begin
                start = 1'b1;
                slot = 0;
            end
            else if (slot == 0 && $urandom_range(0, 149) == 0)
            begin
                start = 1'b1;
            end
            if (start)
                gen_pos = 0;
            if (slot == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    do
                        data = 8'($urandom_range(0, 255));
                    while (data[7:4] < spuadpcm_pkg::NUM_FILTERS
                           && data[3:0] <= spuadpcm_pkg::MAX_SHIFT);
                end
                else
                begin
                    data = {4'($urandom_range(0, spuadpcm_pkg::NUM_FILTERS - 1)),
                            4'($urandom_range(0, spuadpcm_pkg::MAX_SHIFT))};
                end
            end
            else if (slot == 1)
            begin
                if ($urandom_range(0, 3) == 0)
                    data = 8'($urandom_range(0, 255));
                else
                    data = 8'($urandom_range(0, 7));
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                data = $urandom_range(0, 1) ? 8'h77 : 8'h88;
            end
            else
            begin
                data = 8'($urandom_range(0, 255));
            end
            queue_byte(data, start);
            gen_pos = gen_pos + 1;
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (sample_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && sample_pairs.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ spu_adpcm_block_decoder.f @@
hdl/spuadpcm_pkg.sv
hdl/spuadpcm_filter.sv
hdl/spu_adpcm_block_decoder.sv
sim/tb.sv
